// ===== hdl/vvf_pkg.sv =====
// ----------------------------------------------------------------------------
// vvf_pkg: shared definitions of the viewport fit block
// Widths, register indexes, fit mode codes and the sideband that travels
// alongside the divider pipeline.
// ----------------------------------------------------------------------------
package vvf_pkg;

	localparam int DIM_BITS    = 13;
	localparam int DIVD_BITS   = 2 * DIM_BITS;
	localparam int DIV_STEPS   = DIVD_BITS;
	localparam int DIV_LANES   = 2;
	localparam int LANE_W      = 0;
	localparam int LANE_H      = 1;
	localparam int PCT_SCALE   = 100;
	localparam int BORDER_BITS = 8;
	localparam int CFG_BITS    = DIM_BITS;
	localparam int TDATA_BITS  = ((4 * DIM_BITS + 7) / 8) * 8;

	typedef logic [DIM_BITS-1:0]  dim_t;
	typedef logic [DIVD_BITS-1:0] wide_t;

	typedef enum logic [1:0] {
		REG_BORDER   = 2'd0,
		REG_FIT_MODE = 2'd1,
		REG_PARAM_W  = 2'd2,
		REG_PARAM_H  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		FIT_FULL         = 3'd0,
		FIT_PERCENT      = 3'd1,
		FIT_ORIG_SIZE    = 3'd2,
		FIT_CUSTOM_SIZE  = 3'd3,
		FIT_ORIG_RATIO   = 3'd4,
		FIT_CUSTOM_RATIO = 3'd5
	} fit_mode_t;

	// Per-item context carried through the divider stages
	typedef struct packed {
		logic empty;
		logic wide;
		logic rh_zero;
		dim_t sw;
		dim_t sh;
		dim_t pw;
		dim_t ph;
	} side_t;

endpackage

// ===== hdl/vvf_div.sv =====
// ----------------------------------------------------------------------------
// vvf_div: pipelined two-lane restoring divider
// One quotient bit per stage in each lane; a context word and a valid bit
// travel with every item. All stages advance together on en.
// ----------------------------------------------------------------------------
module vvf_div (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   en,
	input  logic                                                   in_valid,
	input  logic [vvf_pkg::DIV_LANES-1:0][vvf_pkg::DIVD_BITS-1:0] in_dvd,
	input  logic [vvf_pkg::DIV_LANES-1:0][vvf_pkg::DIM_BITS-1:0]  in_dvs,
	input  vvf_pkg::side_t                                         in_side,
	output logic                                                   out_valid,
	output logic [vvf_pkg::DIV_LANES-1:0][vvf_pkg::DIVD_BITS-1:0] out_quo,
	output vvf_pkg::side_t                                         out_side
);

	localparam int STEPS = vvf_pkg::DIV_STEPS;
	localparam int LANES = vvf_pkg::DIV_LANES;
	localparam int DW    = vvf_pkg::DIM_BITS;
	localparam int QW    = vvf_pkg::DIVD_BITS;

	logic                          vld_s  [STEPS];
	logic [LANES-1:0][DW-1:0]      rem_s  [STEPS];
	logic [LANES-1:0][QW-1:0]      dd_s   [STEPS];
	logic [LANES-1:0][DW-1:0]      dvs_s  [STEPS];
	vvf_pkg::side_t                side_s [STEPS];

	logic [LANES-1:0][DW-1:0]      prv_rem [STEPS];
	logic [LANES-1:0][QW-1:0]      prv_dd  [STEPS];
	logic [LANES-1:0][DW-1:0]      prv_dvs [STEPS];
	logic [LANES-1:0][DW-1:0]      nxt_rem [STEPS];
	logic [LANES-1:0][QW-1:0]      nxt_dd  [STEPS];

	// Stage inputs: the ports for the first stage, the stage before otherwise
	always_comb begin
		prv_rem[0] = '0;
		prv_dd[0]  = in_dvd;
		prv_dvs[0] = in_dvs;
		for (int k = 1; k < STEPS; k++) begin
			prv_rem[k] = rem_s[k-1];
			prv_dd[k]  = dd_s[k-1];
			prv_dvs[k] = dvs_s[k-1];
		end
	end

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		logic [DW+1:0] diff;
		diff = '0;
		for (int k = 0; k < STEPS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				diff = {1'b0, prv_rem[k][l], prv_dd[k][l][QW-1]} - {2'b00, prv_dvs[k][l]};
				if (diff[DW+1]) begin
					nxt_rem[k][l] = {prv_rem[k][l][DW-2:0], prv_dd[k][l][QW-1]};
					nxt_dd[k][l]  = {prv_dd[k][l][QW-2:0], 1'b0};
				end else begin
					nxt_rem[k][l] = diff[DW-1:0];
					nxt_dd[k][l]  = {prv_dd[k][l][QW-2:0], 1'b1};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STEPS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < STEPS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int k = 0; k < STEPS; k++) begin
				rem_s[k] <= nxt_rem[k];
				dd_s[k]  <= nxt_dd[k];
				dvs_s[k] <= prv_dvs[k];
			end
			for (int k = 1; k < STEPS; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_quo   = dd_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

// ===== hdl/video_viewport_fit_top.sv =====
// ----------------------------------------------------------------------------
// video_viewport_fit_top: letterbox placement of a video rectangle
// Takes a window size, a picture size and a playing flag per request and
// returns the centred, clamped video rectangle inside the bordered window.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream, one transfer per request; every request
//   yields exactly one result transfer on the m_ stream, in order.
//   Configuration (border, fit mode, two mode parameters) is written through
//   cfg_we / cfg_index / cfg_data while no request is in flight.
// Pipeline and throughput:
//   A request passes through three setup stages (border and size selection,
//   the two 13x13 products, the ratio compare), 26 stages of the two-lane
//   restoring divider (one quotient bit per stage), then clamp/round,
//   centring and the output register. One request is taken every cycle
//   while s_tready is high; the divider stages set the latency.
// Reset:
//   arst_n clears the configuration to border 0, full mode, parameters 1,
//   and empties the pipeline.
// Stall:
//   When m_tready is low the result holds in the output register; one more
//   result drops into a skid register, after which the whole pipeline and
//   s_tready hold until the output drains. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module video_viewport_fit_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [vvf_pkg::CFG_BITS-1:0]       cfg_data,
	// request stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// s_tdata, low bit up: win_width, win_height, pic_width, pic_height
	input  logic [vvf_pkg::TDATA_BITS-1:0]     s_tdata,
	// s_tuser: playing
	input  logic                               s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata, low bit up: rect_x, rect_y, rect_w, rect_h
	output logic [vvf_pkg::TDATA_BITS-1:0]     m_tdata,
	// m_tuser: valid_res
	output logic                               m_tuser
);

	localparam int DW = vvf_pkg::DIM_BITS;
	localparam int QW = vvf_pkg::DIVD_BITS;

	typedef struct packed {
		logic          ok;
		vvf_pkg::dim_t x;
		vvf_pkg::dim_t y;
		vvf_pkg::dim_t w;
		vvf_pkg::dim_t h;
	} res_t;

	// Clamp a candidate size to the usable extent and round down to 4 pixels
	function automatic vvf_pkg::dim_t fit_clamp(vvf_pkg::wide_t cand, vvf_pkg::dim_t lim);
		vvf_pkg::dim_t r;
		r = (cand > vvf_pkg::wide_t'(lim)) ? lim : cand[DW-1:0];
		return {r[DW-1:2], 2'b00};
	endfunction

	// ---------------- configuration registers ----------------
	logic [vvf_pkg::BORDER_BITS-1:0] border_q;
	vvf_pkg::fit_mode_t              fit_mode_q;
	vvf_pkg::dim_t                   param_w_q;
	vvf_pkg::dim_t                   param_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_q   <= '0;
			fit_mode_q <= vvf_pkg::FIT_FULL;
			param_w_q  <= vvf_pkg::dim_t'(1);
			param_h_q  <= vvf_pkg::dim_t'(1);
		end else if (cfg_we) begin
			unique case (vvf_pkg::reg_idx_t'(cfg_index))
				vvf_pkg::REG_BORDER: begin
					border_q <= cfg_data[vvf_pkg::BORDER_BITS-1:0];
				end
				vvf_pkg::REG_FIT_MODE: begin
					fit_mode_q <= vvf_pkg::fit_mode_t'(cfg_data[2:0]);
				end
				vvf_pkg::REG_PARAM_W: begin
					param_w_q <= cfg_data[DW-1:0];
				end
				vvf_pkg::REG_PARAM_H: begin
					param_h_q <= cfg_data[DW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	// Every stage advances together; hold only while the skid register is full.
	logic en;
	logic skid_v_q;
	logic out_v_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// ---------------- stage 1: usable area and picture size ----------------
	logic [DW:0]   b2_c;
	vvf_pkg::dim_t ww_c, wh_c, pic_w_c, pic_h_c, sw_c, sh_c;
	logic          empty_c;

	always_comb begin
		ww_c    = s_tdata[DW-1:0];
		wh_c    = s_tdata[2*DW-1:DW];
		pic_w_c = s_tdata[3*DW-1:2*DW];
		pic_h_c = s_tdata[4*DW-1:3*DW];
		b2_c    = (DW+1)'(border_q) << 1;
		empty_c = ({1'b0, ww_c} <= b2_c) || ({1'b0, wh_c} <= b2_c);
		sw_c    = ww_c - b2_c[DW-1:0];
		sh_c    = wh_c - b2_c[DW-1:0];
	end

	logic          v_s1, empty_s1;
	vvf_pkg::dim_t sw_s1, sh_s1, pw_s1, ph_s1;

	// ---------------- stage 2: products ----------------
	// Percent mode scales the picture by the parameters; the ratio modes form
	// the cross products rw*sh and sw*rh, which also serve as dividends.
	logic          pct_c;
	vvf_pkg::dim_t rw_c, rh_c, ma_c, mb_c, na_c, nb_c;

	always_comb begin
		pct_c = (fit_mode_q == vvf_pkg::FIT_PERCENT);
		rw_c  = (fit_mode_q == vvf_pkg::FIT_CUSTOM_RATIO) ? param_w_q : pw_s1;
		rh_c  = (fit_mode_q == vvf_pkg::FIT_CUSTOM_RATIO) ? param_h_q : ph_s1;
		ma_c  = pct_c ? pw_s1 : rw_c;
		na_c  = pct_c ? param_w_q : sh_s1;
		mb_c  = pct_c ? ph_s1 : sw_s1;
		nb_c  = pct_c ? param_h_q : rh_c;
	end

	logic           v_s2, empty_s2;
	vvf_pkg::dim_t  sw_s2, sh_s2, pw_s2, ph_s2, rw_s2, rh_s2;
	vvf_pkg::wide_t a_s2, b_s2;

	// ---------------- stage 3: ratio compare ----------------
	logic           v_s3, empty_s3, wide_s3;
	vvf_pkg::dim_t  sw_s3, sh_s3, pw_s3, ph_s3, rw_s3, rh_s3;
	vvf_pkg::wide_t a_s3, b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			empty_s1 <= empty_c;
			sw_s1    <= sw_c;
			sh_s1    <= sh_c;
			// A stopped stream or an unknown side falls back to the usable area
			pw_s1    <= (s_tuser && pic_w_c != '0) ? pic_w_c : sw_c;
			ph_s1    <= (s_tuser && pic_h_c != '0) ? pic_h_c : sh_c;

			empty_s2 <= empty_s1;
			sw_s2    <= sw_s1;
			sh_s2    <= sh_s1;
			pw_s2    <= pw_s1;
			ph_s2    <= ph_s1;
			rw_s2    <= rw_c;
			rh_s2    <= rh_c;
			a_s2     <= QW'(ma_c) * QW'(na_c);
			b_s2     <= QW'(mb_c) * QW'(nb_c);

			empty_s3 <= empty_s2;
			wide_s3  <= (a_s2 > b_s2);
			sw_s3    <= sw_s2;
			sh_s3    <= sh_s2;
			pw_s3    <= pw_s2;
			ph_s3    <= ph_s2;
			rw_s3    <= rw_s2;
			rh_s3    <= rh_s2;
			a_s3     <= a_s2;
			b_s3     <= b_s2;
		end
	end

	// ---------------- divider ----------------
	// Width lane: a / rh (or / 100); height lane: b / rw (or / 100).
	logic [vvf_pkg::DIV_LANES-1:0][QW-1:0] div_dvd;
	logic [vvf_pkg::DIV_LANES-1:0][DW-1:0] div_dvs;
	logic [vvf_pkg::DIV_LANES-1:0][QW-1:0] div_quo;
	vvf_pkg::side_t                        div_side_in, div_side_out;
	logic                                  div_valid;

	always_comb begin
		div_dvd[vvf_pkg::LANE_W] = a_s3;
		div_dvd[vvf_pkg::LANE_H] = b_s3;
		div_dvs[vvf_pkg::LANE_W] = pct_c ? DW'(vvf_pkg::PCT_SCALE) : rh_s3;
		div_dvs[vvf_pkg::LANE_H] = pct_c ? DW'(vvf_pkg::PCT_SCALE) : rw_s3;
		div_side_in.empty   = empty_s3;
		div_side_in.wide    = wide_s3;
		div_side_in.rh_zero = (rh_s3 == '0);
		div_side_in.sw      = sw_s3;
		div_side_in.sh      = sh_s3;
		div_side_in.pw      = pw_s3;
		div_side_in.ph      = ph_s3;
	end

	vvf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_dvd    (div_dvd),
		.in_dvs    (div_dvs),
		.in_side   (div_side_in),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_side  (div_side_out)
	);

	// ---------------- stage 4: target size, clamp, round ----------------
	vvf_pkg::wide_t cand_w_c, cand_h_c;

	always_comb begin
		unique case (fit_mode_q)
			vvf_pkg::FIT_PERCENT: begin
				cand_w_c = div_quo[vvf_pkg::LANE_W];
				cand_h_c = div_quo[vvf_pkg::LANE_H];
			end
			vvf_pkg::FIT_ORIG_SIZE: begin
				cand_w_c = QW'(div_side_out.pw);
				cand_h_c = QW'(div_side_out.ph);
			end
			vvf_pkg::FIT_CUSTOM_SIZE: begin
				cand_w_c = QW'(param_w_q);
				cand_h_c = QW'(param_h_q);
			end
			vvf_pkg::FIT_ORIG_RATIO, vvf_pkg::FIT_CUSTOM_RATIO: begin
				if (div_side_out.wide) begin
					// target wider than the area: full width, derived height
					cand_w_c = QW'(div_side_out.sw);
					cand_h_c = div_quo[vvf_pkg::LANE_H];
				end else begin
					// full height, derived width; a zero denominator gives width 0
					cand_w_c = div_side_out.rh_zero ? '0 : div_quo[vvf_pkg::LANE_W];
					cand_h_c = QW'(div_side_out.sh);
				end
			end
			default: begin
				cand_w_c = QW'(div_side_out.sw);
				cand_h_c = QW'(div_side_out.sh);
			end
		endcase
	end

	logic          v_s4, empty_s4;
	vvf_pkg::dim_t sw_s4, sh_s4, dw_s4, dh_s4;

	// ---------------- stage 5: centring ----------------
	logic [DW:0] x_c, y_c;

	always_comb begin
		x_c = (DW+1)'(border_q) + (DW+1)'((sw_s4 - dw_s4) >> 1);
		y_c = (DW+1)'(border_q) + (DW+1)'((sh_s4 - dh_s4) >> 1);
	end

	logic v_s5;
	res_t res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= div_valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			empty_s4 <= div_side_out.empty;
			sw_s4    <= div_side_out.sw;
			sh_s4    <= div_side_out.sh;
			dw_s4    <= fit_clamp(cand_w_c, div_side_out.sw);
			dh_s4    <= fit_clamp(cand_h_c, div_side_out.sh);

			// An empty usable area reports all zeros with the flag clear
			if (empty_s4) begin
				res_s5 <= '0;
			end else begin
				res_s5.ok <= 1'b1;
				res_s5.x  <= x_c[DW-1:0];
				res_s5.y  <= y_c[DW-1:0];
				res_s5.w  <= dw_s4;
				res_s5.h  <= dh_s4;
			end
		end
	end

	// ---------------- output register and skid ----------------
	res_t out_q, skid_q;
	logic out_free;
	logic leave;

	assign out_free = !out_v_q || m_tready;
	assign leave    = en && v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			// drain the skid first, else take straight from the pipeline
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= leave;
			end
		end else if (leave) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : res_s5;
		end else if (leave) begin
			skid_q <= res_s5;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.ok;
	assign m_tdata  = vvf_pkg::TDATA_BITS'({out_q.h, out_q.w, out_q.y, out_q.x});

endmodule
